[hw/rtl/vwfp_pkg.sv]
package vwfp_pkg;

  localparam int unsigned NUM_FIELDS     = 6;
  localparam int unsigned HEADER_BITS    = 24;
  localparam int unsigned WORD_W         = 64;
  localparam int unsigned WIDTH_BITS     = 7;
  localparam int unsigned NUM_OFFSETS    = 6;
  localparam int unsigned FIELD_WIDTHS_W = WIDTH_BITS * NUM_OFFSETS;
  localparam int unsigned CFG_INDEX_W    = 3;
  localparam int unsigned FCNT_W         = 3;
  localparam int unsigned FIFO_DEPTH     = 4;
  localparam int unsigned FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [WIDTH_BITS-1:0] FREE_RESET = WIDTH_BITS'(WORD_W - HEADER_BITS);
  localparam logic [WIDTH_BITS-1:0] FULL_WORD  = WIDTH_BITS'(WORD_W);

  typedef enum logic [1:0] {
    STATUS_EXACT     = 2'd0,
    STATUS_REJECTED  = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIELD_WIDTHS  = 3'd0,
    REG_SATURATE_MODE = 3'd1,
    REG_OFFSET_0      = 3'd2,
    REG_OFFSET_1      = 3'd3,
    REG_OFFSET_2      = 3'd4,
    REG_OFFSET_3      = 3'd5,
    REG_OFFSET_4      = 3'd6,
    REG_OFFSET_5      = 3'd7
  } reg_index_e;

  typedef struct packed {
    logic [FIELD_WIDTHS_W-1:0]          widths;
    logic                               saturate;
    logic [NUM_OFFSETS-1:0][WORD_W-1:0] offsets;
  } pack_cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0]     acc;
    logic [WIDTH_BITS-1:0] free;
    logic [FCNT_W-1:0]     fcnt;
    status_e               sticky;
  } pack_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    status_e           status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]           count;
    logic                 last;
    out_item_t [1:0]      items;
  } pack_res_t;

endpackage

[hw/rtl/vwfp_if.sv]
interface vwfp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] field_value;

  modport source (output valid, output field_value, input ready);
  modport sink (input valid, input field_value, output ready);
endinterface

interface vwfp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_word;
  logic        last_word;
  logic [1:0]  status;

  modport source (output valid, output packed_word, output last_word, output status,
                  input ready);
  modport sink (input valid, input packed_word, input last_word, input status,
                output ready);
endinterface

[hw/rtl/vwfp_pack_unit.sv]
module vwfp_pack_unit (
  input  logic [vwfp_pkg::WORD_W-1:0] value_i,
  input  vwfp_pkg::pack_cfg_t         cfg_i,
  input  vwfp_pkg::pack_state_t       state_i,
  output vwfp_pkg::pack_state_t       state_o,
  output vwfp_pkg::pack_res_t         res_o
);

  logic [vwfp_pkg::FCNT_W-1:0]     f;
  logic [vwfp_pkg::WIDTH_BITS-1:0] w_raw;
  logic [vwfp_pkg::WIDTH_BITS-1:0] b;
  logic [vwfp_pkg::WORD_W-1:0]     off;
  logic [vwfp_pkg::WORD_W-1:0]     mask;
  logic [vwfp_pkg::WORD_W-1:0]     diff;
  logic [vwfp_pkg::WORD_W-1:0]     v;
  logic                            fits;
  logic                            spill_en;
  logic [vwfp_pkg::WIDTH_BITS-1:0] spill;
  logic [vwfp_pkg::WORD_W-1:0]     spill_word;
  logic [vwfp_pkg::WORD_W-1:0]     acc1;
  logic [vwfp_pkg::WORD_W-1:0]     acc2;
  logic [vwfp_pkg::WIDTH_BITS-1:0] free1;
  logic [vwfp_pkg::WIDTH_BITS-1:0] free2;
  logic [vwfp_pkg::WIDTH_BITS-1:0] b1;
  logic                            is_last;
  vwfp_pkg::status_e               sticky;

  always_comb begin
    f       = (state_i.fcnt >= vwfp_pkg::FCNT_W'(vwfp_pkg::NUM_FIELDS)) ? '0 : state_i.fcnt;
    w_raw   = cfg_i.widths[int'(f) * vwfp_pkg::WIDTH_BITS +: vwfp_pkg::WIDTH_BITS];
    b       = (w_raw > vwfp_pkg::FULL_WORD) ? vwfp_pkg::FULL_WORD : w_raw;
    off     = cfg_i.offsets[f];
    mask    = b[6] ? '1 : ((64'd1 << b[5:0]) - 64'd1);
    diff    = value_i - off;
    fits    = (value_i >= off) && ((diff & ~mask) == '0);

    sticky = state_i.sticky;
    if (fits) begin
      v = diff & mask;
    end else if (cfg_i.saturate) begin
      v = mask;
      if (state_i.sticky != vwfp_pkg::STATUS_REJECTED) begin
        sticky = vwfp_pkg::STATUS_SATURATED;
      end
    end else begin
      v      = '0;
      sticky = vwfp_pkg::STATUS_REJECTED;
    end

    spill_en   = b > state_i.free;
    spill      = b - state_i.free;
    spill_word = state_i.acc | (spill[6] ? '0 : (v >> spill[5:0]));
    if (spill_en) begin
      acc1  = '0;
      free1 = vwfp_pkg::FULL_WORD;
      b1    = spill;
    end else begin
      acc1  = state_i.acc;
      free1 = state_i.free;
      b1    = b;
    end
    free2 = free1 - b1;
    acc2  = free2[6] ? acc1 : (acc1 | (v << free2[5:0]));

    is_last = f == vwfp_pkg::FCNT_W'(vwfp_pkg::NUM_FIELDS - 1);

    res_o.last            = is_last;
    res_o.count           = 2'(spill_en) + 2'(is_last);
    res_o.items[1].word   = acc2;
    res_o.items[1].last   = 1'b1;
    res_o.items[1].status = sticky;
    if (spill_en) begin
      res_o.items[0].word   = spill_word;
      res_o.items[0].last   = 1'b0;
      res_o.items[0].status = vwfp_pkg::STATUS_EXACT;
    end else begin
      res_o.items[0] = res_o.items[1];
    end

    if (is_last) begin
      state_o.acc    = '0;
      state_o.free   = vwfp_pkg::FREE_RESET;
      state_o.fcnt   = '0;
      state_o.sticky = vwfp_pkg::STATUS_EXACT;
    end else begin
      state_o.acc    = acc2;
      state_o.free   = free2;
      state_o.fcnt   = f + vwfp_pkg::FCNT_W'(1);
      state_o.sticky = sticky;
    end
  end

endmodule

[hw/rtl/vwfp_out_fifo.sv]
module vwfp_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [1:0]                     push_cnt_i,
  input  vwfp_pkg::out_item_t [1:0]      push_items_i,
  output logic                           space_o,
  vwfp_out_if.source                     word_o
);

  vwfp_pkg::out_item_t               mem [vwfp_pkg::FIFO_DEPTH];
  logic [vwfp_pkg::FIFO_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [vwfp_pkg::FIFO_CNT_W-1:0]   count_q, count_d;
  logic                              pop;

  assign pop     = (count_q != '0) && word_o.ready;
  assign space_o = count_q <= vwfp_pkg::FIFO_CNT_W'(vwfp_pkg::FIFO_DEPTH - 2);

  always_comb begin
    wr_d    = wr_q + vwfp_pkg::FIFO_PTR_W'(push_cnt_i);
    rd_d    = rd_q + vwfp_pkg::FIFO_PTR_W'(pop);
    count_d = count_q + vwfp_pkg::FIFO_CNT_W'(push_cnt_i) - vwfp_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem[wr_q] <= push_items_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      mem[wr_q + vwfp_pkg::FIFO_PTR_W'(1)] <= push_items_i[1];
    end
  end

  assign word_o.valid       = count_q != '0;
  assign word_o.packed_word = mem[rd_q].word;
  assign word_o.last_word   = mem[rd_q].last;
  assign word_o.status      = mem[rd_q].status;

endmodule

[hw/rtl/variable_width_field_packer_core.sv]
// variable-width field packer
// field_i takes one field value per transaction, fields of a key in order
// 0..5; each gets its offset subtracted, is range checked against its
// configured width and packed msb first after a 24-bit zero header gap.
// word_o delivers 64-bit packed words; the word carrying last_word also
// carries the key status (exact, rejected, saturated).
// configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i); the
// user writes it only while no transaction is in flight; the block does not enforce it.
// a field's words reach word_o through the input register and then the output queue.
// throughput: one field per cycle while the queue has room, set by the
// single input register feeding the pack logic; a field that both spills a
// word and ends the key pushes two words, and the output drains one word per
// cycle while word_o is ready, through a four-entry queue that holds field_i
// off when fewer than two entries are free; a stall on word_o fills the
// queue and then back-pressures field_i; no word is dropped.
// reset clears the configuration, the queue and the key state at once.
module variable_width_field_packer_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [vwfp_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [vwfp_pkg::WORD_W-1:0]          cfg_data_i,
  vwfp_in_if.sink                              field_i,
  vwfp_out_if.source                           word_o
);

  vwfp_pkg::pack_cfg_t     cfg_q, cfg_d;
  vwfp_pkg::pack_state_t   state_q, state_next;
  vwfp_pkg::pack_res_t     res;
  logic [vwfp_pkg::WORD_W-1:0] in_q;
  logic                    in_valid_q, in_valid_d;
  logic                    space;
  logic                    advance;
  logic                    accept;
  logic [1:0]              push_cnt;

  assign advance       = in_valid_q && space;
  assign field_i.ready = !in_valid_q || advance;
  assign accept        = field_i.valid && field_i.ready;
  assign push_cnt      = advance ? res.count : 2'd0;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (vwfp_pkg::reg_index_e'(cfg_index_i))
        vwfp_pkg::REG_FIELD_WIDTHS:  cfg_d.widths = cfg_data_i[vwfp_pkg::FIELD_WIDTHS_W-1:0];
        vwfp_pkg::REG_SATURATE_MODE: cfg_d.saturate = cfg_data_i[0];
        vwfp_pkg::REG_OFFSET_0:      cfg_d.offsets[0] = cfg_data_i;
        vwfp_pkg::REG_OFFSET_1:      cfg_d.offsets[1] = cfg_data_i;
        vwfp_pkg::REG_OFFSET_2:      cfg_d.offsets[2] = cfg_data_i;
        vwfp_pkg::REG_OFFSET_3:      cfg_d.offsets[3] = cfg_data_i;
        vwfp_pkg::REG_OFFSET_4:      cfg_d.offsets[4] = cfg_data_i;
        vwfp_pkg::REG_OFFSET_5:      cfg_d.offsets[5] = cfg_data_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q          <= '0;
      in_valid_q     <= 1'b0;
      state_q.acc    <= '0;
      state_q.free   <= vwfp_pkg::FREE_RESET;
      state_q.fcnt   <= '0;
      state_q.sticky <= vwfp_pkg::STATUS_EXACT;
    end else begin
      cfg_q      <= cfg_d;
      in_valid_q <= in_valid_d;
      if (advance) begin
        state_q <= state_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= field_i.field_value;
    end
  end

  vwfp_pack_unit u_pack (
    .value_i (in_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_next),
    .res_o   (res)
  );

  vwfp_out_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cnt_i   (push_cnt),
    .push_items_i (res.items),
    .space_o      (space),
    .word_o       (word_o)
  );

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.free <= vwfp_pkg::FULL_WORD) &&
    (state_q.fcnt < vwfp_pkg::FCNT_W'(vwfp_pkg::NUM_FIELDS)))
    else $error("pack state out of range");

  a_key_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.last |=> (state_q.fcnt == '0) && (state_q.acc == '0) &&
      (state_q.free == vwfp_pkg::FREE_RESET))
    else $error("key state not restarted after last field");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !space |=> in_valid_q && $stable(in_q))
    else $error("input register lost a field while blocked");

endmodule

[dv/tb.sv]
module tb;
  import vwfp_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef struct {
    logic [63:0] word;
    logic        last;
    status_e     status;
  } packed_word_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [63:0]       cfg_data;

  vwfp_in_if  fld ();
  vwfp_out_if wrd ();

  variable_width_field_packer_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .field_i     (fld),
    .word_o      (wrd)
  );

  // shadow of the block's configuration and key state
  logic [41:0]       cfg_widths;
  logic              cfg_saturate;
  logic [63:0]       cfg_offsets [6];
  logic [63:0]       acc_word;
  int unsigned       bits_left;
  int unsigned       next_field;
  status_e           key_status;

  packed_word_t      pending_words [$];
  int unsigned       error_count;
  longint unsigned   cycle_count;
  logic              no_idle;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    wrd.ready <= no_idle || ($urandom_range(99) >= 21);
  end

  function automatic int unsigned width_of(int unsigned f);
    int unsigned w;
    w = cfg_widths[7*f +: 7];
    return (w > 64) ? 64 : w;
  endfunction

  function automatic logic [63:0] ones_of(int unsigned b);
    if (b == 0) return 64'd0;
    return ~64'd0 >> (64 - b);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void start_key();
    acc_word   = 64'd0;
    bits_left  = 64 - HEADER_BITS;
    next_field = 0;
    key_status = STATUS_EXACT;
  endfunction

  // predicts the words caused by one accepted field value
  function automatic void pack_field(logic [63:0] value);
    int unsigned  f;
    int unsigned  b;
    int unsigned  spill;
    logic [63:0]  v;
    logic [63:0]  mask;
    logic [63:0]  top;
    logic         fits;
    packed_word_t w;
    f = (next_field >= NUM_FIELDS) ? 0 : next_field;
    b = width_of(f);
    mask = ones_of(b);
    v = value;
    if (v < cfg_offsets[f]) begin
      fits = 1'b0;
      v = 64'd0;
    end else begin
      v = v - cfg_offsets[f];
      fits = (v & ~mask) == 64'd0;
    end
    if (!fits) begin
      if (cfg_saturate) begin
        v = mask;
        if (key_status != STATUS_REJECTED) key_status = STATUS_SATURATED;
      end else begin
        v = 64'd0;
        key_status = STATUS_REJECTED;
      end
    end
    v = v & mask;
    if (b > bits_left) begin
      spill = b - bits_left;
      top = (v >> 1) >> (spill - 1);
      w.word = acc_word | top;
      w.last = 1'b0;
      w.status = STATUS_EXACT;
      pending_words.push_back(w);
      acc_word = 64'd0;
      bits_left = 64;
      b = spill;
    end
    bits_left = bits_left - b;
    if (bits_left < 64) acc_word = acc_word | (v << bits_left);
    if (f + 1 >= NUM_FIELDS) begin
      w.word = acc_word;
      w.last = 1'b1;
      w.status = key_status;
      pending_words.push_back(w);
      start_key();
    end else begin
      next_field = f + 1;
    end
  endfunction

  always @(posedge clk) begin
    packed_word_t w;
    if (rst_n && wrd.valid && wrd.ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word %h", wrd.packed_word);
        error_count++;
      end else begin
        w = pending_words.pop_front();
        if (wrd.packed_word !== w.word) begin
          $error("packed_word expected %h actual %h", w.word, wrd.packed_word);
          error_count++;
        end
        if (wrd.last_word !== w.last) begin
          $error("last_word expected %0d actual %0d", w.last, wrd.last_word);
          error_count++;
        end
        if (wrd.status !== w.status) begin
          $error("status expected %0d actual %0d", w.status, wrd.status);
          error_count++;
        end
      end
    end
  end

  task automatic send_field(logic [63:0] value);
    if (!no_idle && $urandom_range(99) < 11) begin
      fld.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    fld.valid <= 1'b1;
    fld.field_value <= value;
    @(posedge clk);
    while (!fld.ready) @(posedge clk);
    pack_field(value);
  endtask

  task automatic wait_drained();
    fld.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_e idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_FIELD_WIDTHS:  cfg_widths = data[41:0];
      REG_SATURATE_MODE: cfg_saturate = data[0];
      default:           cfg_offsets[int'(idx) - int'(REG_OFFSET_0)] = data;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] widths_word(int unsigned w0, int unsigned w1,
                                             int unsigned w2, int unsigned w3,
                                             int unsigned w4, int unsigned w5);
    logic [63:0] r;
    r = 64'd0;
    r[6:0]   = w0[6:0];
    r[13:7]  = w1[6:0];
    r[20:14] = w2[6:0];
    r[27:21] = w3[6:0];
    r[34:28] = w4[6:0];
    r[41:35] = w5[6:0];
    return r;
  endfunction

  function automatic int unsigned rand_width();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 64;
      2:       return $urandom_range(65, 127);
      default: return $urandom_range(1, 63);
    endcase
  endfunction

  function automatic logic [63:0] rand_offset();
    case ($urandom_range(9))
      0, 1, 2: return 64'd0;
      3:       return ~64'd0;
      4, 5:    return rand64();
      default: return 64'($urandom_range(0, 1000));
    endcase
  endfunction

  // mostly in-range values for the field that comes next, some off range
  function automatic logic [63:0] rand_field_value();
    int unsigned f;
    int unsigned sel;
    logic [63:0] mask;
    logic [63:0] off;
    f = (next_field >= NUM_FIELDS) ? 0 : next_field;
    mask = ones_of(width_of(f));
    off = cfg_offsets[f];
    sel = $urandom_range(99);
    if (sel < 70) return off + (rand64() & mask);
    if (sel < 80) return rand64();
    if (sel < 90) return off - 64'($urandom_range(1, 4));
    return off + mask + 64'($urandom_range(1, 4));
  endfunction

  task automatic config_all(logic [63:0] widths, logic sat, logic [63:0] off);
    write_reg(REG_FIELD_WIDTHS, widths);
    write_reg(REG_SATURATE_MODE, {63'd0, sat});
    for (int i = 0; i < 6; i++) write_reg(reg_index_e'(int'(REG_OFFSET_0) + i), off);
  endtask

  task automatic random_config();
    write_reg(REG_FIELD_WIDTHS, widths_word(rand_width(), rand_width(), rand_width(),
              rand_width(), rand_width(), rand_width()) |
              (rand64() & 64'hFFFF_FC00_0000_0000));
    write_reg(REG_SATURATE_MODE, rand64());
    for (int i = 0; i < 6; i++) write_reg(reg_index_e'(int'(REG_OFFSET_0) + i), rand_offset());
  endtask

  task automatic test_reset_state();
    // all widths zero: zeros fit, a nonzero value is rejected
    for (int i = 0; i < 5; i++) send_field(64'd0);
    send_field(64'd1);
    wait_drained();
  endtask

  task automatic test_strict_extremes();
    write_reg(REG_FIELD_WIDTHS, widths_word(64, 127, 0, 40, 1, 63) | 64'hFFFF_FC00_0000_0000);
    write_reg(REG_SATURATE_MODE, 64'd0);
    write_reg(REG_OFFSET_0, 64'd0);
    write_reg(REG_OFFSET_1, ~64'd0);
    write_reg(REG_OFFSET_2, 64'd0);
    write_reg(REG_OFFSET_3, 64'd5);
    write_reg(REG_OFFSET_4, 64'd0);
    write_reg(REG_OFFSET_5, 64'd1);
    send_field(~64'd0);
    send_field(~64'd0);
    send_field(64'd0);
    send_field(64'd4);
    send_field(64'd1);
    send_field(64'd0);
    wait_drained();
  endtask

  task automatic test_saturate_full_word();
    // five 8-bit fields fill the first word exactly, the last spills whole
    config_all(widths_word(8, 8, 8, 8, 8, 8), 1'b1, 64'd0);
    send_field(64'd300);
    send_field(64'd255);
    send_field(64'd0);
    send_field(64'hA5);
    send_field(64'd1);
    send_field(64'd255);
    wait_drained();
  endtask

  task automatic test_mixed_status_mid_key();
    config_all(widths_word(10, 10, 10, 10, 10, 10), 1'b1, 64'd0);
    send_field(64'd2000);
    wait_drained();
    write_reg(REG_SATURATE_MODE, 64'd0);
    send_field(64'd1024);
    wait_drained();
    write_reg(REG_SATURATE_MODE, 64'd1);
    send_field(~64'd0);
    send_field(64'd1023);
    send_field(64'd7);
    send_field(64'd0);
    wait_drained();
  endtask

  task automatic test_random_keys();
    for (int phase = 0; phase < 14; phase++) begin
      wait_drained();
      case (phase)
        0:       config_all(widths_word(127, 127, 127, 127, 127, 127), 1'b1, 64'd0);
        1:       config_all(64'd0, 1'b0, ~64'd0);
        2:       config_all(widths_word(64, 64, 64, 64, 64, 64), 1'b0, ~64'd0);
        default: random_config();
      endcase
      no_idle = (phase == 4);
      for (int k = 0; k < 20; k++) begin
        for (int f = 0; f < 6; f++) begin
          if (k == 10 && f == 3) begin
            wait_drained();
            write_reg(REG_SATURATE_MODE, {63'd0, ~cfg_saturate});
          end
          send_field(rand_field_value());
        end
      end
      no_idle = 1'b0;
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FIELD_WIDTHS;
    cfg_data = 64'd0;
    fld.valid = 1'b0;
    fld.field_value = 64'd0;
    wrd.ready = 1'b0;
    no_idle = 1'b0;
    error_count = 0;
    cycle_count = 0;
    cfg_widths = '0;
    cfg_saturate = 1'b0;
    for (int i = 0; i < 6; i++) cfg_offsets[i] = 64'd0;
    start_key();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_strict_extremes();
    test_saturate_full_word();
    test_mixed_status_mid_key();
    test_random_keys();

    wait_drained();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
